### hdl/abciq_pkg.sv
// Package for the audio buffer completion interrupt queue.
// Holds action and buffer codes, register indexes, controller states and the
// command and status types shared by the controller and the datapath.
package abciq_pkg;

	localparam int OFF_W     = 21;
	localparam int BUF_W     = 2;
	localparam int ACT_W     = 3;
	localparam int CNT_OUT_W = 3;
	localparam int CFG_IDX_W = 1;

	// A buffer counts as completed when its last 32-bit word is written.
	localparam int LAST_WORD_BYTES = 4;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE      = 3'd0,
		ACT_PLAY       = 3'd1,
		ACT_TICK       = 3'd2,
		ACT_TYPE_READ  = 3'd3,
		ACT_CONSUME    = 3'd4,
		ACT_POWER_DOWN = 3'd5
	} action_t;

	localparam logic [BUF_W-1:0] BUF_NONE = 2'd0;
	localparam logic [BUF_W-1:0] BUF_A    = 2'd1;
	localparam logic [BUF_W-1:0] BUF_B    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BUF_A_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BUF_B_BASE = 1'b1;

	localparam logic [OFF_W-1:0] BUF_A_BASE_RST = 21'd0;
	localparam logic [OFF_W-1:0] BUF_B_BASE_RST = 21'd2048;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EXEC,
		ST_PUSH_B,
		ST_ALT,
		ST_RESULT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_DECODE,
		OP_WRITE,
		OP_PLAY_ON,
		OP_PUSH_B,
		OP_RAISE_ALT,
		OP_PLAY_OFF,
		OP_TICK,
		OP_TYPE_READ,
		OP_CONSUME,
		OP_POWER_DOWN,
		OP_LOAD_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		action_t action;
		logic    enable;
		logic    playing;
		logic    out_free;
	} dp_status_t;

endpackage

### hdl/abciq_if.sv
// Channel interfaces of the audio buffer completion interrupt queue.
// abciq_req_if carries one access, abciq_rsp_if one result; both use abciq_pkg.
interface abciq_req_if;
	import abciq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ACT_W-1:0]     action;
	logic [OFF_W-1:0]     offset;
	logic                 enable;
	logic [BUF_W-1:0]     consume_bit;
	logic                 line_busy;
	logic                 token_pending;

	modport source (
		output valid, action, offset, enable, consume_bit, line_busy, token_pending,
		input  ready
	);
	modport sink (
		input  valid, action, offset, enable, consume_bit, line_busy, token_pending,
		output ready
	);
endinterface

interface abciq_rsp_if;
	import abciq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 raise_irq;
	logic [BUF_W-1:0]     irq_buffer;
	logic [BUF_W-1:0]     send_mask;
	logic                 consumed;
	logic [CNT_OUT_W-1:0] queued_count;
	logic                 playing;

	modport source (
		output valid, raise_irq, irq_buffer, send_mask, consumed, queued_count, playing,
		input  ready
	);
	modport sink (
		input  valid, raise_irq, irq_buffer, send_mask, consumed, queued_count, playing,
		output ready
	);
endinterface

### hdl/abciq_datapath.sv
// Datapath of the audio buffer completion interrupt queue: base registers,
// captured access, completion FIFO, playback state and the result register.
// Driven by abciq_ctrl through dp_cmd_t; uses abciq_pkg.
module abciq_datapath import abciq_pkg::*; #(
	parameter int BUFFER_BYTES = 2048,
	parameter int FIFO_DEPTH   = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [OFF_W-1:0]     cfg_wdata,
	input  logic [ACT_W-1:0]     action,
	input  logic [OFF_W-1:0]     offset,
	input  logic                 enable,
	input  logic [BUF_W-1:0]     consume_bit,
	input  logic                 line_busy,
	input  logic                 token_pending,
	input  dp_cmd_t              cmd,
	output dp_status_t           st,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 raise_irq,
	output logic [BUF_W-1:0]     irq_buffer,
	output logic [BUF_W-1:0]     send_mask,
	output logic                 consumed,
	output logic [CNT_OUT_W-1:0] queued_count,
	output logic                 playing
);

	localparam int IW    = $clog2(FIFO_DEPTH);
	localparam int CW    = $clog2(FIFO_DEPTH + 1);
	localparam int SUM_W = OFF_W + 1;

	// Configuration registers.
	logic [OFF_W-1:0] a_base_q, b_base_q;

	// Captured access.
	action_t          action_q;
	logic [OFF_W-1:0] off_q;
	logic             enable_q;
	logic [BUF_W-1:0] cbit_q;
	logic             line_busy_q;
	logic             token_q;

	// Decode results.
	logic [BUF_W-1:0] hit_q;
	logic             found_q;
	logic [IW-1:0]    idx_q;

	// Block state.
	logic             playing_q;
	logic [BUF_W-1:0] ready_q;
	logic             ready_b_q;
	logic             await_q;
	logic [BUF_W-1:0] alt_q;
	logic [BUF_W-1:0] fifo_q [FIFO_DEPTH];
	logic [BUF_W-1:0] fifo_up [FIFO_DEPTH];
	logic [CW-1:0]    count_q;

	// Result being built and the output register.
	logic             raised_q;
	logic [BUF_W-1:0] raised_bit_q;
	logic [BUF_W-1:0] send_q;
	logic             consumed_q;
	logic             out_valid_q;

	logic [SUM_W-1:0] off_x, a_x, b_x, bytes_x, last_x;
	logic             in_a, last_a, last_b;
	logic [BUF_W-1:0] hit_c;
	logic             found_c;
	logic [IW-1:0]    idx_c;
	logic             full;
	logic             push_en, pop_en, rm_en, clr_en, tick_ok;
	logic [BUF_W-1:0] push_bit;
	logic             raise_en;
	logic [BUF_W-1:0] raise_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_base_q <= BUF_A_BASE_RST;
			b_base_q <= BUF_B_BASE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BUF_A_BASE: a_base_q <= cfg_wdata;
				REG_BUF_B_BASE: b_base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			action_q    <= action_t'(action);
			off_q       <= offset;
			enable_q    <= enable;
			cbit_q      <= consume_bit;
			line_busy_q <= line_busy;
			token_q     <= token_pending;
		end
	end

	// Buffer A wins where the two buffers overlap: any offset inside A
	// that is not A's last word is ignored even if it is B's last word.
	always_comb begin
		off_x   = {1'b0, off_q};
		a_x     = {1'b0, a_base_q};
		b_x     = {1'b0, b_base_q};
		bytes_x = SUM_W'(BUFFER_BYTES);
		last_x  = bytes_x - SUM_W'(LAST_WORD_BYTES);
		in_a    = (off_x >= a_x) && (off_x < a_x + bytes_x);
		last_a  = off_x == a_x + last_x;
		last_b  = off_x == b_x + last_x;
		if (last_a)
			hit_c = BUF_A;
		else if (!in_a && last_b)
			hit_c = BUF_B;
		else
			hit_c = BUF_NONE;
	end

	// First live FIFO entry that matches the consume request.
	always_comb begin
		found_c = 1'b0;
		idx_c   = '0;
		for (int i = 0; i < FIFO_DEPTH; i++) begin
			if (!found_c && CW'(i) < count_q && fifo_q[i] == cbit_q && cbit_q != BUF_NONE) begin
				found_c = 1'b1;
				idx_c   = IW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DECODE) begin
			hit_q   <= hit_c;
			found_q <= found_c;
			idx_q   <= idx_c;
		end
	end

	// The FIFO is kept as a shift line with the oldest entry at index 0.
	for (genvar g = 0; g < FIFO_DEPTH; g++) begin : g_up
		if (g < FIFO_DEPTH - 1) begin : g_mid
			assign fifo_up[g] = fifo_q[g+1];
		end else begin : g_top
			assign fifo_up[g] = BUF_NONE;
		end
	end

	assign full    = count_q == CW'(FIFO_DEPTH);
	assign tick_ok = playing_q && !line_busy_q && !token_q && !await_q && (count_q != '0);

	always_comb begin
		push_en  = 1'b0;
		push_bit = BUF_NONE;
		case (cmd.op)
			OP_WRITE: begin
				if (playing_q && hit_q != BUF_NONE) begin
					push_en  = 1'b1;
					push_bit = hit_q;
				end
			end
			OP_PLAY_ON: begin
				if (ready_q[0]) begin
					push_en  = 1'b1;
					push_bit = BUF_A;
				end
			end
			OP_PUSH_B: begin
				if (ready_b_q) begin
					push_en  = 1'b1;
					push_bit = BUF_B;
				end
			end
			default: ;
		endcase
	end

	assign pop_en = (cmd.op == OP_TICK) && tick_ok;
	assign rm_en  = (cmd.op == OP_CONSUME) && found_q;
	assign clr_en = (cmd.op == OP_PLAY_OFF) || (cmd.op == OP_POWER_DOWN && playing_q);

	always_comb begin
		raise_en  = 1'b0;
		raise_bit = BUF_NONE;
		if (cmd.op == OP_TICK && tick_ok && fifo_q[0] != BUF_NONE) begin
			raise_en  = 1'b1;
			raise_bit = fifo_q[0];
		end else if (cmd.op == OP_RAISE_ALT && count_q == '0 && !line_busy_q
				&& alt_q != BUF_NONE) begin
			raise_en  = 1'b1;
			raise_bit = alt_q;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < FIFO_DEPTH; i++) begin
			if (push_en) begin
				if (full)
					fifo_q[i] <= (i == FIFO_DEPTH - 1) ? push_bit : fifo_up[i];
				else if (count_q == CW'(i))
					fifo_q[i] <= push_bit;
			end else if (pop_en) begin
				fifo_q[i] <= fifo_up[i];
			end else if (rm_en && IW'(i) >= idx_q) begin
				fifo_q[i] <= fifo_up[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr_en) begin
			count_q <= '0;
		end else if (push_en) begin
			if (!full)
				count_q <= count_q + CW'(1);
		end else if (pop_en || rm_en) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q    <= 1'b0;
			ready_q      <= BUF_NONE;
			ready_b_q    <= 1'b0;
			await_q      <= 1'b0;
			alt_q        <= BUF_A;
			raised_q     <= 1'b0;
			raised_bit_q <= BUF_NONE;
			send_q       <= BUF_NONE;
			consumed_q   <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CAPTURE: begin
					raised_q     <= 1'b0;
					raised_bit_q <= BUF_NONE;
					send_q       <= BUF_NONE;
					consumed_q   <= 1'b0;
				end
				OP_WRITE: begin
					if (hit_q != BUF_NONE) begin
						if (!playing_q)
							ready_q <= ready_q | hit_q;
						else
							send_q <= hit_q;
					end
				end
				OP_PLAY_ON: begin
					playing_q <= 1'b1;
					await_q   <= 1'b0;
					ready_q   <= BUF_NONE;
					ready_b_q <= ready_q[1];
					send_q    <= {1'b0, ready_q[0]};
				end
				OP_PUSH_B: begin
					if (ready_b_q)
						send_q[1] <= 1'b1;
				end
				OP_PLAY_OFF: begin
					playing_q <= 1'b0;
					ready_q   <= BUF_NONE;
					await_q   <= 1'b0;
				end
				OP_TYPE_READ: begin
					await_q <= 1'b0;
				end
				OP_CONSUME: begin
					consumed_q <= found_q;
				end
				OP_POWER_DOWN: begin
					if (playing_q) begin
						playing_q <= 1'b0;
						await_q   <= 1'b0;
					end
				end
				default: ;
			endcase
			if (raise_en) begin
				await_q      <= 1'b1;
				alt_q        <= (raise_bit == BUF_A) ? BUF_B : BUF_A;
				raised_q     <= 1'b1;
				raised_bit_q <= raise_bit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_LOAD_OUT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD_OUT) begin
			raise_irq    <= raised_q;
			irq_buffer   <= raised_bit_q;
			send_mask    <= send_q;
			consumed     <= consumed_q;
			queued_count <= CNT_OUT_W'(count_q);
			playing      <= playing_q;
		end
	end

	assign out_valid = out_valid_q;

	assign st.action   = action_q;
	assign st.enable   = enable_q;
	assign st.playing  = playing_q;
	assign st.out_free = !out_valid_q || out_ready;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(FIFO_DEPTH))
		else $error("completion FIFO count exceeds its depth");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		playing_q |-> ready_q == BUF_NONE)
		else $error("ready mask holds buffers while playback is on");

	a_raise_await: assert property (@(posedge clk) disable iff (!arst_n)
		raised_q |-> await_q)
		else $error("interrupt raised without waiting for its type read");

endmodule

### hdl/abciq_ctrl.sv
// Controller of the audio buffer completion interrupt queue: sequences each
// access through capture, decode, execute, the playback-enable steps and
// result load in abciq_datapath. Uses abciq_pkg.
module abciq_ctrl import abciq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_DECODE;
			end
			ST_DECODE: state_d = ST_EXEC;
			ST_EXEC: begin
				if (st.action == ACT_PLAY && st.enable && !st.playing)
					state_d = ST_PUSH_B;
				else
					state_d = ST_RESULT;
			end
			ST_PUSH_B: state_d = ST_ALT;
			ST_ALT:    state_d = ST_RESULT;
			ST_RESULT: begin
				if (st.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					cmd.op = OP_CAPTURE;
			end
			ST_DECODE: cmd.op = OP_DECODE;
			ST_EXEC: begin
				case (st.action)
					ACT_WRITE: cmd.op = OP_WRITE;
					ACT_PLAY: begin
						if (st.enable && !st.playing)
							cmd.op = OP_PLAY_ON;
						else if (!st.enable && st.playing)
							cmd.op = OP_PLAY_OFF;
					end
					ACT_TICK:       cmd.op = OP_TICK;
					ACT_TYPE_READ:  cmd.op = OP_TYPE_READ;
					ACT_CONSUME:    cmd.op = OP_CONSUME;
					ACT_POWER_DOWN: cmd.op = OP_POWER_DOWN;
					default:        cmd.op = OP_NONE;
				endcase
			end
			ST_PUSH_B: cmd.op = OP_PUSH_B;
			ST_ALT:    cmd.op = OP_RAISE_ALT;
			ST_RESULT: begin
				if (st.out_free)
					cmd.op = OP_LOAD_OUT;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && !st.out_free) |=> state_q == ST_RESULT)
		else $error("result dropped while the output register was occupied");

endmodule

### hdl/audio_buffer_completion_irq_queue.sv
// Audio buffer completion interrupt queue, top level.
// Accesses arrive on req (valid/ready): buffer writes, playback enable and
// disable, interrupt ticks, interrupt type reads, consume requests and DAC
// power down. Every access yields exactly one result on rsp: the interrupt
// raised (if any), the buffers handed to playback, whether a consume hit,
// the FIFO fill after the access and the playback state.
// The base registers of A and B are set via cfg_wr_en, cfg_index, cfg_wdata;
// the user must write them only while no access is in flight (not enforced).
// An access is handled by a controller state machine over the datapath: a
// transfer on req is followed by a decode state and an execute state, and the
// result is then loaded into the output register, which drives rsp.valid.
// Enabling playback adds ST_PUSH_B, which queues buffer B behind buffer A,
// and ST_ALT, for the alternate-buffer interrupt. A new access is taken
// only after the previous one has loaded its result.
// The next access is taken while a result still waits in the output register;
// if rsp stays stalled, that access waits in its result state until the
// register frees. Reset stops playback, empties the FIFO, clears the ready
// mask and sets buffer A as the next alternate buffer.
module audio_buffer_completion_irq_queue import abciq_pkg::*; #(
	parameter int BUFFER_BYTES = 2048,
	parameter int FIFO_DEPTH   = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [OFF_W-1:0]     cfg_wdata,
	abciq_req_if.sink            req,
	abciq_rsp_if.source          rsp
);

	dp_cmd_t    cmd;
	dp_status_t st;
	logic       in_ready;

	abciq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	abciq_datapath #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.FIFO_DEPTH   (FIFO_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.action        (req.action),
		.offset        (req.offset),
		.enable        (req.enable),
		.consume_bit   (req.consume_bit),
		.line_busy     (req.line_busy),
		.token_pending (req.token_pending),
		.cmd           (cmd),
		.st            (st),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.raise_irq     (rsp.raise_irq),
		.irq_buffer    (rsp.irq_buffer),
		.send_mask     (rsp.send_mask),
		.consumed      (rsp.consumed),
		.queued_count  (rsp.queued_count),
		.playing       (rsp.playing)
	);

	assign req.ready = in_ready;

endmodule
